### design/hva_pkg.sv
package hva_pkg;

    localparam int BLOCK_W     = 23;
    localparam int LEVEL_W     = 2;
    localparam int OFFSET_W    = 35;
    localparam int BASE_W      = 21;
    localparam int COPIES_W    = 2;
    localparam int TOTAL_W     = 23;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    localparam int BLOCK_SHIFT = 12;
    localparam int FANOUT      = 170;
    localparam int SPAN2       = FANOUT * FANOUT;
    localparam int SPAN3       = FANOUT * FANOUT * FANOUT;

    // floor(n / d) = (n * ceil(2^s / d)) >> s, exact for every 23-bit n
    localparam int RECIP_W = 24;
    localparam int PROD_W  = BLOCK_W + RECIP_W;
    localparam int SHIFT1  = 31;
    localparam int SHIFT2  = 38;
    localparam logic [RECIP_W-1:0] RECIP1 = RECIP_W'(((64'd1 << SHIFT1) + FANOUT - 1) / FANOUT);
    localparam logic [RECIP_W-1:0] RECIP2 = RECIP_W'(((64'd1 << SHIFT2) + SPAN2 - 1) / SPAN2);
    localparam int Q1_W = PROD_W - SHIFT1;
    localparam int Q2_W = PROD_W - SHIFT2;

    localparam int STEP1_W  = 8;
    localparam int STEP2_W  = 15;
    localparam int TAB_W    = 24;
    localparam int BLK_W    = 25;
    localparam int EXTRA_W  = 20;
    localparam int TEXTRA_W = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_VOLUME_BASE  = 2'd0,
        CFG_TABLE_COPIES = 2'd1,
        CFG_TOTAL_BLOCKS = 2'd2
    } cfg_reg_t;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_LEAF = 2'd0,
        LEVEL_MID  = 2'd1,
        LEVEL_TOP  = 2'd2
    } table_level_t;

    typedef struct packed {
        logic                out_of_range;
        logic [OFFSET_W-1:0] table_offset;
        logic [OFFSET_W-1:0] data_offset;
    } result_t;

endpackage

### design/hashed_volume_block_address.sv
// hashed volume block address unit
// input channel s_axis: one transaction per block lookup, tdata carries the
// logical block number and the hash table level wanted
// output channel m_axis: one transaction per lookup, in order, with the data
// block byte offset and the covering table byte offset in tdata and the
// out-of-range flag in tuser (data offset reads zero when it is set)
// configuration: cfg_wr_en writes cfg_wdata to the register at cfg_addr
// (volume base, table copies, total blocks); write only while idle
// latency: a result appears on m_axis four cycles after its input is taken
// throughput: one lookup per cycle; the stages are the input register, the
// two reciprocal multipliers, the quotient register, the table step
// multipliers and the final adds
// reset: the pipeline empties, volume base returns to 0, table copies and
// total blocks to 1
// stall: a one-entry skid register behind the output register takes the last
// result in flight; s_axis_tready falls while it is full and the pipeline
// holds, so nothing is dropped or repeated
module hashed_volume_block_address
    import hva_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // block_number, table_level, zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // data_offset, table_offset, zero pad
    output logic                   m_axis_tuser   // out_of_range
);

    logic [BASE_W-1:0]   base_reg;
    logic [COPIES_W-1:0] copies_reg;
    logic [TOTAL_W-1:0]  total_reg;

    logic                en;
    logic [STEP1_W-1:0]  step1;
    logic [STEP2_W-1:0]  step2;

    // stage 1: input register
    logic                v1_reg;
    logic [BLOCK_W-1:0]  n1_reg;
    logic [LEVEL_W-1:0]  lvl1_reg;

    // stage 2: reciprocal products
    logic                v2_reg;
    logic [BLOCK_W-1:0]  n2_reg;
    logic [LEVEL_W-1:0]  lvl2_reg;
    logic                bad2_reg, ge1_2_reg, ge2_2_reg, q3_2_reg;
    logic [PROD_W-1:0]   p1_reg, p2_reg;
    logic [PROD_W-1:0]   p1_next, p2_next;

    // stage 3: quotients
    logic                v3_reg;
    logic [BLOCK_W-1:0]  n3_reg;
    logic [LEVEL_W-1:0]  lvl3_reg;
    logic                bad3_reg, ge1_3_reg, ge2_3_reg, q3_3_reg;
    logic [Q1_W-1:0]     q1_reg;
    logic [Q2_W-1:0]     q2_reg;

    // stage 4: table steps and copy counts
    logic                v4_reg;
    logic [BLOCK_W-1:0]  n4_reg;
    logic [LEVEL_W-1:0]  lvl4_reg;
    logic                bad4_reg, ge1_4_reg, ge2_4_reg;
    logic [TAB_W-1:0]    tab0_reg, tab1_reg;
    logic [EXTRA_W-1:0]  dextra_reg;
    logic [TEXTRA_W-1:0] textra_reg;
    logic [TAB_W-1:0]    tab0_next, tab1_next;
    logic [EXTRA_W-1:0]  dextra_next;
    logic [TEXTRA_W-1:0] textra_next;

    // output and skid
    logic [BLK_W-1:0]    dblk, tblk;
    result_t             res_next;
    result_t             out_reg, skid_reg;
    logic                out_v_reg, skid_v_reg;
    logic                out_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            copies_reg <= COPIES_W'(1);
            total_reg  <= TOTAL_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_VOLUME_BASE:  base_reg   <= cfg_wdata[BASE_W-1:0];
                CFG_TABLE_COPIES: copies_reg <= cfg_wdata[COPIES_W-1:0];
                CFG_TOTAL_BLOCKS: total_reg  <= cfg_wdata[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign en            = !skid_v_reg;
    assign s_axis_tready = en;
    assign step1 = STEP1_W'(FANOUT) + STEP1_W'(copies_reg);
    assign step2 = STEP2_W'(SPAN2) + STEP2_W'(FANOUT + 1) * STEP2_W'(copies_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign p1_next = PROD_W'(n1_reg) * PROD_W'(RECIP1);
    assign p2_next = PROD_W'(n1_reg) * PROD_W'(RECIP2);

    always_comb begin
        tab0_next = TAB_W'(q1_reg) * TAB_W'(step1);
        tab1_next = TAB_W'(q2_reg) * TAB_W'(step2);
        dextra_next = (EXTRA_W'(q1_reg) + EXTRA_W'(1)) * EXTRA_W'(copies_reg);
        if (ge1_3_reg) begin
            dextra_next = dextra_next
                        + (EXTRA_W'(q2_reg) + EXTRA_W'(1)) * EXTRA_W'(copies_reg);
        end
        if (ge2_3_reg) begin
            dextra_next = dextra_next
                        + (EXTRA_W'(q3_3_reg) + EXTRA_W'(1)) * EXTRA_W'(copies_reg);
        end
        textra_next = (TEXTRA_W'(q2_reg) + TEXTRA_W'(1)) * TEXTRA_W'(copies_reg);
        if (ge2_3_reg) begin
            textra_next = textra_next + TEXTRA_W'(copies_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg   <= s_axis_tdata[BLOCK_W-1:0];
            lvl1_reg <= s_axis_tdata[BLOCK_W +: LEVEL_W];

            n2_reg    <= n1_reg;
            lvl2_reg  <= lvl1_reg;
            bad2_reg  <= (n1_reg >= total_reg);
            ge1_2_reg <= (n1_reg >= BLOCK_W'(FANOUT));
            ge2_2_reg <= (n1_reg >= BLOCK_W'(SPAN2));
            q3_2_reg  <= (n1_reg >= BLOCK_W'(SPAN3));
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;

            n3_reg    <= n2_reg;
            lvl3_reg  <= lvl2_reg;
            bad3_reg  <= bad2_reg;
            ge1_3_reg <= ge1_2_reg;
            ge2_3_reg <= ge2_2_reg;
            q3_3_reg  <= q3_2_reg;
            q1_reg    <= p1_reg[SHIFT1 +: Q1_W];
            q2_reg    <= p2_reg[SHIFT2 +: Q2_W];

            n4_reg     <= n3_reg;
            lvl4_reg   <= lvl3_reg;
            bad4_reg   <= bad3_reg;
            ge1_4_reg  <= ge1_3_reg;
            ge2_4_reg  <= ge2_3_reg;
            tab0_reg   <= tab0_next;
            tab1_reg   <= tab1_next;
            dextra_reg <= dextra_next;
            textra_reg <= textra_next;
        end
    end

    always_comb begin
        dblk = BLK_W'(n4_reg) + BLK_W'(dextra_reg);
        if (lvl4_reg == LEVEL_TOP) begin
            tblk = BLK_W'(step2);
        end else if (lvl4_reg == LEVEL_MID) begin
            tblk = ge2_4_reg ? BLK_W'(tab1_reg) + BLK_W'(copies_reg) : BLK_W'(step1);
        end else begin
            tblk = ge1_4_reg ? BLK_W'(tab0_reg) + BLK_W'(textra_reg) : '0;
        end
        res_next.out_of_range = bad4_reg;
        res_next.data_offset  = bad4_reg ? '0
                              : OFFSET_W'(base_reg) + OFFSET_W'({dblk, {BLOCK_SHIFT{1'b0}}});
        res_next.table_offset = OFFSET_W'(base_reg) + OFFSET_W'({tblk, {BLOCK_SHIFT{1'b0}}});
    end

    assign out_take = !out_v_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (out_take) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else if (en) begin
                out_v_reg <= v4_reg;
            end
        end else if (en && v4_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            if (skid_v_reg) begin
                out_reg <= skid_reg;
            end else if (en) begin
                out_reg <= res_next;
            end
        end else if (en && v4_reg) begin
            skid_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * OFFSET_W){1'b0}},
                            out_reg.table_offset, out_reg.data_offset};
    assign m_axis_tuser  = out_reg.out_of_range;

`ifndef NO_ASSERTIONS
    skid_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid register full while output register empty");

    bad_block_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[OFFSET_W-1:0] == '0))
        else $error("out-of-range transaction carries a data offset");

    reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> (!m_axis_tvalid && s_axis_tready))
        else $error("pipeline not empty after reset");
`endif

endmodule

### tb/sv/hashed_volume_block_address_tb.sv
`timescale 1ns / 1ps

module hashed_volume_block_address_tb
    import hva_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 100;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // local copy of the configuration registers
    logic [BASE_W-1:0]   vol_base;
    logic [COPIES_W-1:0] copy_count;
    logic [TOTAL_W-1:0]  block_total;

    result_t pending_lookups[$];
    int      mismatch_count;
    int      stall_cycles;
    int      hold_left;
    bit      src_idle;
    bit      sink_idle;

    hashed_volume_block_address i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic result_t predict_offsets(logic [BLOCK_W-1:0] blk,
                                                logic [LEVEL_W-1:0] lvl);
        result_t         r;
        longint unsigned n;
        longint unsigned c;
        longint unsigned extra;
        longint unsigned tab;
        longint unsigned step1;
        longint unsigned step2;
        n = blk;
        c = copy_count;
        extra = (n / FANOUT + 1) * c;
        if (n >= FANOUT) begin
            extra += (n / SPAN2 + 1) * c;
            if (n >= SPAN2) begin
                extra += (n / SPAN3 + 1) * c;
            end
        end
        step1 = FANOUT + c;
        step2 = SPAN2 + (FANOUT + 1) * c;
        case (lvl)
            LEVEL_TOP: begin
                tab = step2;
            end
            LEVEL_MID: begin
                tab = (n < SPAN2) ? step1 : (n / SPAN2) * step2 + c;
            end
            default: begin
                // level three falls back to the leaf level
                if (n < FANOUT) begin
                    tab = 0;
                end else begin
                    tab = (n / FANOUT) * step1 + (n / SPAN2 + 1) * c;
                    if (n >= SPAN2) begin
                        tab += c;
                    end
                end
            end
        endcase
        r.out_of_range = (n >= block_total);
        r.data_offset  = r.out_of_range ? '0
                                        : OFFSET_W'(vol_base + ((n + extra) << BLOCK_SHIFT));
        r.table_offset = OFFSET_W'(vol_base + (tab << BLOCK_SHIFT));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        end
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        case (idx)
            CFG_VOLUME_BASE:  vol_base    = value[BASE_W-1:0];
            CFG_TABLE_COPIES: copy_count  = value[COPIES_W-1:0];
            CFG_TOTAL_BLOCKS: block_total = value[TOTAL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] copies,
                             logic [CFG_DATA_W-1:0] total);
        write_register(CFG_VOLUME_BASE, base);
        write_register(CFG_TABLE_COPIES, copies);
        write_register(CFG_TOTAL_BLOCKS, total);
    endtask

    task automatic send_lookup(logic [BLOCK_W-1:0] blk, logic [LEVEL_W-1:0] lvl);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  = {{(IN_TDATA_W-BLOCK_W-LEVEL_W){1'b0}}, lvl, blk};
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_lookups.insert(pending_lookups.size(), predict_offsets(blk, lvl));
    endtask

    // lets the pipeline run dry before the configuration changes
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic [BLOCK_W-1:0] pick_block();
        logic [BLOCK_W-1:0] b;
        case ($urandom_range(0, 3))
            0: b = (block_total != 0) ? BLOCK_W'($urandom_range(0, block_total - 1))
                                      : BLOCK_W'($urandom());
            1: b = BLOCK_W'($urandom_range(0, 28900) * FANOUT + $urandom_range(0, 2) - 1);
            2: b = BLOCK_W'($urandom_range(0, 170) * SPAN2 + $urandom_range(0, 2) - 1);
            default: b = BLOCK_W'($urandom());
        endcase
        return b;
    endfunction

    task automatic test_reset_values();
        send_lookup(0, LEVEL_LEAF);
        send_lookup(0, LEVEL_TOP);
        send_lookup(1, LEVEL_MID);
        send_lookup(169, LEVEL_LEAF);
        drain();
    endtask

    task automatic test_level_boundaries();
        configure(1048576, 2, CFG_DATA_W'(SPAN3));
        send_lookup(0, LEVEL_MID);
        send_lookup(169, LEVEL_LEAF);
        send_lookup(170, LEVEL_LEAF);
        send_lookup(170, LEVEL_MID);
        send_lookup(28899, LEVEL_LEAF);
        send_lookup(28900, LEVEL_LEAF);
        send_lookup(28900, LEVEL_MID);
        send_lookup(BLOCK_W'(SPAN3 - 1), LEVEL_TOP);
        send_lookup(BLOCK_W'(SPAN3 - 1), 2'd3);
        send_lookup(BLOCK_W'(SPAN3), LEVEL_MID);
        send_lookup({BLOCK_W{1'b1}}, 2'd3);
        drain();
    endtask

    task automatic test_zero_total();
        configure(4096, 1, 0);
        send_lookup(0, LEVEL_LEAF);
        send_lookup(12345, LEVEL_MID);
        drain();
    endtask

    task automatic test_copy_extremes();
        configure(CFG_DATA_W'({BASE_W{1'b1}}), 0, {TOTAL_W{1'b1}});
        send_lookup(28900, LEVEL_LEAF);
        send_lookup(BLOCK_W'({BLOCK_W{1'b1}} - 1), LEVEL_MID);
        drain();
        configure(CFG_DATA_W'({BASE_W{1'b1}}), 3, {TOTAL_W{1'b1}});
        send_lookup(BLOCK_W'({BLOCK_W{1'b1}} - 1), LEVEL_LEAF);
        send_lookup(170, LEVEL_TOP);
        drain();
    endtask

    task automatic test_random_lookups();
        logic [CFG_DATA_W-1:0] base;
        logic [CFG_DATA_W-1:0] copies;
        logic [CFG_DATA_W-1:0] total;
        for (int phase = 0; phase < 5; phase++) begin
            case ($urandom_range(0, 4))
                0: base = 0;
                1: base = 1048576;
                2: base = CFG_DATA_W'({BASE_W{1'b1}});
                3: base = CFG_DATA_W'($urandom_range(0, 256) << BLOCK_SHIFT);
                default: base = CFG_DATA_W'($urandom_range(0, (1 << BASE_W) - 1));
            endcase
            copies = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 3))
                                                 : CFG_DATA_W'($urandom_range(1, 2));
            case ($urandom_range(0, 4))
                0: total = 1;
                1: total = CFG_DATA_W'(SPAN3);
                2: total = {TOTAL_W{1'b1}};
                default: total = CFG_DATA_W'($urandom_range(1, SPAN3));
            endcase
            configure(base, copies, total);
            src_idle  = (phase != 2);
            sink_idle = (phase != 2);
            for (int i = 0; i < 100; i++) begin
                send_lookup(pick_block(), LEVEL_W'($urandom_range(0, 3)));
            end
            drain();
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        configure(8192, 2, CFG_DATA_W'(SPAN3));
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        @(negedge aclk);
        hold_left = 300;
        for (int i = 0; i < 40; i++) begin
            send_lookup(pick_block(), LEVEL_W'($urandom_range(0, 3)));
        end
        drain();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // long receiver hold-off, counted down here
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        wait (aresetn);
        forever begin
            gap = sink_idle ? $urandom_range(0, 19) : 0;
            @(negedge aclk);
            if (gap > 0 || hold_left > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge aclk);
                while (hold_left > 0) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata[63:0], 64'd0);
            end else begin
                want = pending_lookups.pop_front();
                if (m_axis_tdata[OFFSET_W-1:0] !== want.data_offset) begin
                    report_mismatch("data_offset", 64'(m_axis_tdata[OFFSET_W-1:0]),
                                    64'(want.data_offset));
                end
                if (m_axis_tdata[2*OFFSET_W-1:OFFSET_W] !== want.table_offset) begin
                    report_mismatch("table_offset",
                                    64'(m_axis_tdata[2*OFFSET_W-1:OFFSET_W]),
                                    64'(want.table_offset));
                end
                if (m_axis_tuser !== want.out_of_range) begin
                    report_mismatch("out_of_range", 64'(m_axis_tuser),
                                    64'(want.out_of_range));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = CFG_VOLUME_BASE;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        vol_base       = '0;
        copy_count     = 1;
        block_total    = 1;
        mismatch_count = 0;
        stall_cycles   = 0;
        hold_left      = 0;
        src_idle       = 1'b1;
        sink_idle      = 1'b1;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_values();
        test_level_boundaries();
        test_zero_total();
        test_copy_extremes();
        test_random_lookups();
        test_backpressure();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
design/hva_pkg.sv
design/hashed_volume_block_address.sv
tb/sv/hashed_volume_block_address_tb.sv
